FILE: hw/rtl/u8d_pkg.sv
// shared types and constants for the utf-8 decoder
package u8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned StatW = 2;
  localparam int unsigned UsedW = 3;

  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_BAD_LEAD  = 2'd1;
  localparam logic [StatW-1:0] STAT_BAD_CONT  = 2'd2;
  localparam logic [StatW-1:0] STAT_SURROGATE = 2'd3;

  localparam logic [CpW-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [CpW-1:0] CP_QMARK  = 21'h00003F;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [StatW-1:0] status;
    logic [UsedW-1:0] bytes_used;
    logic             last;
  } result_t;

  // up to two results leave the decode step for one byte
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } step_out_t;

endpackage

FILE: hw/rtl/u8d_step.sv
// decode step: sequence state and the per-byte decode logic
module u8d_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           byte_in,
  output u8d_pkg::step_out_t   res
);

  logic [u8d_pkg::CpW-1:0]   pv_r, pv_nxt;
  logic [1:0]                bl_r, bl_nxt;
  logic [u8d_pkg::UsedW-1:0] sl_r, sl_nxt;
  logic [7:0]                lb_r, lb_nxt;

  // first-byte decode, used when idle and after a bad continuation
  logic                      fb_emit;
  logic                      fb_open;
  logic [u8d_pkg::CpW-1:0]   fb_pv;
  logic [u8d_pkg::UsedW-1:0] fb_sl;
  u8d_pkg::result_t          fb_res;

  logic                      is_cont;
  logic [u8d_pkg::CpW-1:0]   acc;
  logic [1:0]                bl_dec;

  always_comb begin
    fb_emit = 1'b0;
    fb_open = 1'b0;
    fb_pv   = '0;
    fb_sl   = '0;
    fb_res.code_point = {13'd0, byte_in};
    fb_res.status     = u8d_pkg::STAT_OK;
    fb_res.bytes_used = 3'd1;
    fb_res.last       = 1'b1;
    if (byte_in[7] == 1'b0) begin
      fb_emit = 1'b1;
    end else if ((byte_in & 8'hE0) == 8'hC0) begin
      fb_open = 1'b1;
      fb_pv   = {16'd0, byte_in[4:0]};
      fb_sl   = 3'd2;
    end else if ((byte_in & 8'hF0) == 8'hE0) begin
      fb_open = 1'b1;
      fb_pv   = {17'd0, byte_in[3:0]};
      fb_sl   = 3'd3;
    end else if ((byte_in & 8'hF8) == 8'hF0) begin
      fb_open = 1'b1;
      fb_pv   = {18'd0, byte_in[2:0]};
      fb_sl   = 3'd4;
    end else begin
      fb_emit       = 1'b1;
      fb_res.status = u8d_pkg::STAT_BAD_LEAD;
    end
  end

  assign is_cont = (byte_in & 8'hC0) == 8'h80;
  assign acc     = {pv_r[u8d_pkg::CpW-7:0], byte_in[5:0]};
  assign bl_dec  = bl_r - 2'd1;

  always_comb begin
    pv_nxt  = pv_r;
    bl_nxt  = bl_r;
    sl_nxt  = sl_r;
    lb_nxt  = lb_r;
    res.cnt = 2'd0;
    res.r0  = fb_res;
    res.r1  = fb_res;
    if (bl_r == 2'd0) begin
      res.cnt = {1'b0, fb_emit};
      if (fb_open) begin
        pv_nxt = fb_pv;
        sl_nxt = fb_sl;
        lb_nxt = byte_in;
        bl_nxt = fb_sl[1:0] - 2'd1;
      end
    end else if (is_cont) begin
      pv_nxt = acc;
      bl_nxt = bl_dec;
      if (bl_dec == 2'd0) begin
        res.cnt           = 2'd1;
        res.r0.bytes_used = sl_r;
        res.r0.last       = 1'b1;
        if (acc >= u8d_pkg::SURR_LO && acc <= u8d_pkg::SURR_HI) begin
          res.r0.code_point = u8d_pkg::CP_QMARK;
          res.r0.status     = u8d_pkg::STAT_SURROGATE;
        end else begin
          res.r0.code_point = acc;
          res.r0.status     = u8d_pkg::STAT_OK;
        end
      end
    end else begin
      // bad continuation: report the lead byte, then restart on this byte
      res.cnt           = fb_emit ? 2'd2 : 2'd1;
      res.r0.code_point = {13'd0, lb_r};
      res.r0.status     = u8d_pkg::STAT_BAD_CONT;
      res.r0.bytes_used = sl_r - {1'b0, bl_r};
      res.r0.last       = ~fb_emit;
      bl_nxt            = 2'd0;
      if (fb_open) begin
        pv_nxt = fb_pv;
        sl_nxt = fb_sl;
        lb_nxt = byte_in;
        bl_nxt = fb_sl[1:0] - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      bl_r <= '0;
      sl_r <= '0;
      lb_r <= '0;
    end else if (take) begin
      pv_r <= pv_nxt;
      bl_r <= bl_nxt;
      sl_r <= sl_nxt;
      lb_r <= lb_nxt;
    end
  end

  a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
    (bl_r == 2'd0) |-> (res.cnt != 2'd2))
    else $error("two results from an idle decoder");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res.cnt == 2'd2) |-> (!res.r0.last && res.r1.last))
    else $error("last flag misplaced on a result pair");

  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (bl_r != 2'd0) |-> (sl_r >= 3'd2 && sl_r <= 3'd4 && {1'b0, bl_r} < sl_r))
    else $error("open sequence with inconsistent length");

endmodule

FILE: hw/rtl/u8d_rbuf.sv
// two-entry result buffer between the decode step and the output port
module u8d_rbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  u8d_pkg::step_out_t   res,
  output logic [1:0]           room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8d_pkg::result_t     head
);

  u8d_pkg::result_t e0_r, e0_nxt;
  u8d_pkg::result_t e1_r, e1_nxt;
  logic [1:0]       oc_r, oc_nxt;

  logic             pop;
  logic [1:0]       cnt1;
  logic [1:0]       n;
  u8d_pkg::result_t a0;

  assign out_valid = oc_r != 2'd0;
  assign head      = e0_r;
  assign pop       = out_valid && out_ready;
  assign cnt1      = oc_r - {1'b0, pop};
  assign a0        = pop ? e1_r : e0_r;
  assign room      = 2'd2 - cnt1;
  assign n         = push ? res.cnt : 2'd0;

  always_comb begin
    e0_nxt = a0;
    e1_nxt = e1_r;
    case (cnt1)
      2'd0: begin
        e0_nxt = res.r0;
        e1_nxt = res.r1;
      end
      2'd1: begin
        e1_nxt = res.r0;
      end
      default: begin
        e1_nxt = e1_r;
      end
    endcase
    oc_nxt = cnt1 + n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r <= '0;
    end else begin
      oc_r <= oc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (res.cnt <= room))
    else $error("result buffer overflow");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r != 2'd3)
    else $error("result buffer fill count out of range");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (oc_r == $past(oc_r) - 2'd1))
    else $error("fill count wrong after a lone pop");

endmodule

FILE: hw/rtl/utf8_to_codepoint_decoder.sv
// utf-8 byte stream to code point decoder, top level
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_byte_in[7:0]
//  out_     output     out_valid/out_ready  out_code_point, out_status, out_bytes_used, out_last
//
// one byte per cycle is taken while the result buffer has room; each result passes the input
// register and the result buffer before it is offered; a bad continuation followed by a complete
// first byte yields two results and may hold the input while the two-entry result buffer drains
// synchronous active-low reset returns the decoder to idle with an empty buffer
// out_ready low stalls the buffer; the input register then fills and in_ready drops
module utf8_to_codepoint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic [1:0]  out_status,
  output logic [2:0]  out_bytes_used,
  output logic        out_last
);

  logic               hold_r;
  logic [7:0]         byte_r;
  logic               consume;
  logic [1:0]         room;
  u8d_pkg::step_out_t res;
  u8d_pkg::result_t   head;

  // a held byte moves on only when the buffer has space for all its results
  assign consume  = hold_r && (res.cnt <= room);
  assign in_ready = !hold_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_r <= 1'b1;
    end else if (consume) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
    end
  end

  u8d_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (consume),
    .byte_in (byte_r),
    .res     (res)
  );

  u8d_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (consume),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_code_point = head.code_point;
  assign out_status     = head.status;
  assign out_bytes_used = head.bytes_used;
  assign out_last       = head.last;

endmodule

FILE: bench/utf8_to_codepoint_decoder_test.sv
// testbench for the utf-8 decoder: byte streams checked against a behavioural decoder
`timescale 1ns / 100ps

module utf8_to_codepoint_decoder_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 60;
  localparam int RANDOM_BYTES  = 600;
  localparam int DRAIN_CYCLES  = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_byte_in = 8'h00;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [20:0] out_code_point;
  logic [1:0]  out_status;
  logic [2:0]  out_bytes_used;
  logic        out_last;

  logic [7:0]       stream_bytes [$];
  u8d_pkg::result_t pending_code_points [$];

  // behavioural decoder state
  logic [20:0] dec_partial = '0;
  logic [1:0]  dec_left    = '0;
  logic [2:0]  dec_len     = '0;
  logic [7:0]  dec_lead    = '0;

  int bytes_taken = 0;
  int total_bytes = 0;
  int hold_left   = 0;
  int holds_done  = 0;
  int cycle_count = 0;
  int fails       = 0;

  utf8_to_codepoint_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_bytes_used (out_bytes_used),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  // byte seen while no sequence is open: pass through, flag, or open a sequence
  task automatic take_first_byte(input logic [7:0] b, output bit emitted,
                                 output u8d_pkg::result_t r);
    emitted      = 1'b1;
    r.code_point = {13'd0, b};
    r.status     = u8d_pkg::STAT_OK;
    r.bytes_used = 3'd1;
    r.last       = 1'b1;
    if (b < 8'h80) begin
      r.status = u8d_pkg::STAT_OK;
    end else if ((b & 8'hE0) == 8'hC0) begin
      dec_partial = {16'd0, b[4:0]};
      dec_len     = 3'd2;
      emitted     = 1'b0;
    end else if ((b & 8'hF0) == 8'hE0) begin
      dec_partial = {17'd0, b[3:0]};
      dec_len     = 3'd3;
      emitted     = 1'b0;
    end else if ((b & 8'hF8) == 8'hF0) begin
      dec_partial = {18'd0, b[2:0]};
      dec_len     = 3'd4;
      emitted     = 1'b0;
    end else begin
      r.status = u8d_pkg::STAT_BAD_LEAD;
    end
    if (!emitted) begin
      dec_lead = b;
      dec_left = 2'(dec_len - 3'd1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    u8d_pkg::result_t r;
    u8d_pkg::result_t r2;
    bit               emitted;
    if (dec_left == 2'd0) begin
      take_first_byte(b, emitted, r);
      if (emitted) pending_code_points.push_back(r);
    end else if (b[7:6] == 2'b10) begin
      dec_partial = {dec_partial[14:0], b[5:0]};
      dec_left    = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        r.bytes_used = dec_len;
        r.last       = 1'b1;
        if (dec_partial >= u8d_pkg::SURR_LO && dec_partial <= u8d_pkg::SURR_HI) begin
          r.code_point = u8d_pkg::CP_QMARK;
          r.status     = u8d_pkg::STAT_SURROGATE;
        end else begin
          r.code_point = dec_partial;
          r.status     = u8d_pkg::STAT_OK;
        end
        pending_code_points.push_back(r);
      end
    end else begin
      // broken sequence: report the lead, then treat this byte as a fresh start
      r.code_point = {13'd0, dec_lead};
      r.status     = u8d_pkg::STAT_BAD_CONT;
      r.bytes_used = dec_len - {1'b0, dec_left};
      r.last       = 1'b1;
      dec_left     = 2'd0;
      take_first_byte(b, emitted, r2);
      if (emitted) r.last = 1'b0;
      pending_code_points.push_back(r);
      if (emitted) pending_code_points.push_back(r2);
    end
  endtask

  // lead byte of a len-byte sequence followed by conts continuation bytes
  task automatic push_sequence(input int len, input int conts);
    logic [7:0] lead;
    lead = 8'($urandom_range(255));
    case (len)
      2: lead = 8'hC0 | (lead & 8'h1F);
      3: lead = 8'hE0 | (lead & 8'h0F);
      default: lead = 8'hF0 | (lead & 8'h07);
    endcase
    stream_bytes.push_back(lead);
    for (int k = 0; k < conts; k++) stream_bytes.push_back(8'h80 | 8'($urandom_range(63)));
  endtask

  function automatic int idle_phase();
    if (bytes_taken * 3 < total_bytes) return 0;
    if (bytes_taken * 3 < total_bytes * 2) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_phase())
      0: return 6;
      1: return 87;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (idle_phase())
      0: return 87;
      1: return 6;
      default: return 0;
    endcase
  endfunction

  // driver: holds each byte until the decoder takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte_in);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_valid   <= 1'b1;
          in_byte_in <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with long hold-offs so the decoder backs up and drops in_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && bytes_taken >= 150) ||
                 (holds_done == 1 && bytes_taken >= 520)) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // monitor: every result transaction against the oldest expected result
  always @(posedge clk) begin
    u8d_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_code_points.size() == 0) begin
        $error("unexpected result: code_point %0h status %0d", out_code_point, out_status);
        fails++;
      end else begin
        want = pending_code_points.pop_front();
        if (out_code_point !== want.code_point) begin
          $error("code_point: expected %0h, got %0h", want.code_point, out_code_point);
          fails++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fails++;
        end
        if (out_bytes_used !== want.bytes_used) begin
          $error("bytes_used: expected %0d, got %0d", want.bytes_used, out_bytes_used);
          fails++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int         kind;
    int         len;
    logic [7:0] b;
    // ascii extremes, bad leads, each sequence length, 21-bit maximum,
    // both surrogate edges, broken sequences restarting as ascii, lead and bad lead
    stream_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF,
                     8'hC2, 8'hA9,
                     8'hE2, 8'h82, 8'hAC,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hED, 8'hA0, 8'h80,
                     8'hED, 8'hBF, 8'hBF,
                     8'hC3, 8'h41,
                     8'hE2, 8'h82, 8'hC3, 8'hA9,
                     8'hF0, 8'hF8};
    len = stream_bytes.size();
    while (stream_bytes.size() < len + RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        stream_bytes.push_back(8'($urandom_range(127)));
      end else if (kind < 45) begin
        push_sequence(2, 1);
      end else if (kind < 65) begin
        push_sequence(3, 2);
      end else if (kind < 80) begin
        push_sequence(4, 3);
      end else if (kind < 87) begin
        // surrogate half
        stream_bytes.push_back(8'hED);
        stream_bytes.push_back(8'hA0 | 8'($urandom_range(31)));
        stream_bytes.push_back(8'h80 | 8'($urandom_range(63)));
      end else if (kind < 95) begin
        // truncated sequence ended by a byte that is not a continuation
        kind = $urandom_range(2, 4);
        push_sequence(kind, $urandom_range(kind - 2));
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) begin
          if ($urandom_range(1) == 0) b[7] = 1'b0;
          else b[6] = 1'b1;
        end
        stream_bytes.push_back(b);
      end else begin
        stream_bytes.push_back(8'($urandom_range(255)));
      end
    end
    total_bytes = stream_bytes.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_bytes.size() != 0 || in_valid || pending_code_points.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
